### design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, reset values and command codes for the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CFG_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

### design/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tuser: cmd; tdata: lookup_key, write_value
//   m_*      out  m_tvalid/m_tready   tuser: hit; tdata: read_value
//   cfg_*    in   cfg_wen             cfg_wdata: capacity_in_use
//
// One word per cycle sustained while m_tready is high; a word passes an input
// register, then a result register. The key compare across all entries, the age-rank
// update and the value store write all happen between the two registers.
// Reset clears the valid marks and fill count directly; no clear pass.
// With m_tready low the result holds; the input register takes one word only if it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [63:0]               s_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  wire logic                      s_tuser,   // [0] cmd
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [31:0]                    m_tdata,   // [31:0] read_value
  output logic                           m_tuser,   // [0] hit
  input  wire logic                      cfg_wen,
  input  wire logic [lkvc_pkg::CFG_W-1:0] cfg_wdata
);
  import lkvc_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wen) begin
      cap <= cfg_wdata;
    end
  end

  // input register
  logic             in_valid;
  cmd_t             in_cmd;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;
  logic             advance;
  logic             proc;

  assign advance  = !m_tvalid || m_tready;
  assign proc     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= cmd_t'(s_tuser);
      in_key <= s_tdata[KEY_W-1:0];
      in_val <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  // entry state
  logic [MAX_ENTRIES-1:0] valid;
  logic [KEY_W-1:0]       key  [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank [MAX_ENTRIES];
  logic [CNT_W-1:0]       fill;
  logic [VAL_W-1:0]       value_mem [MAX_ENTRIES];

  // lookup
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] hit_oh;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [MAX_ENTRIES-1:0] evict_cand;
  logic [MAX_ENTRIES-1:0] evict_oh;
  logic [MAX_ENTRIES-1:0] ins_oh;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       ins_idx;
  logic [IDX_W-1:0]       hit_rank;
  logic [CNT_W-1:0]       lru_rank;
  logic [CAP_W-1:0]       cap_eff;
  logic                   full;

  always_comb begin
    if (cap == '0) begin
      cap_eff = CAP_W'(1);
    end else if (CAP_W'(cap) > CAP_W'(MAX_ENTRIES)) begin
      cap_eff = CAP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CAP_W'(cap);
    end
  end

  assign full     = CAP_W'(fill) >= cap_eff;
  assign lru_rank = fill - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]      = valid[i] && (key[i] == in_key);
      evict_cand[i] = valid[i] && (CNT_W'(rank[i]) == lru_rank);
    end
  end

  // lowest set bit of match and evict_cand, lowest clear bit of valid
  assign hit_oh   = match & (~match + MAX_ENTRIES'(1));
  assign free_oh  = ~valid & (valid + MAX_ENTRIES'(1));
  assign evict_oh = evict_cand & (~evict_cand + MAX_ENTRIES'(1));
  assign ins_oh   = full ? evict_oh : free_oh;
  assign hit_any  = |match;

  always_comb begin
    hit_idx  = '0;
    ins_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (ins_oh[i]) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
    end
  end

  // state update
  logic do_insert;
  assign do_insert = proc && !hit_any && (in_cmd == CMD_SET);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (proc) begin
      if (hit_any) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (hit_oh[i]) begin
            rank[i] <= '0;
          end else if (valid[i] && rank[i] < hit_rank) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end else if (in_cmd == CMD_SET) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (ins_oh[i]) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
        if (!full) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (do_insert && ins_oh[i]) begin
        key[i] <= in_key;
      end
    end
  end

  // value store: one write port, one registered read port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] rdata;

  assign mem_we    = proc && (in_cmd == CMD_SET);
  assign mem_waddr = hit_any ? hit_idx : ins_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[mem_waddr] <= in_val;
    end
    if (proc) begin
      rdata <= value_mem[hit_idx];
    end
  end

  // result register
  logic out_use_mem;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tuser     <= hit_any;
      out_use_mem <= hit_any && (in_cmd == CMD_GET);
    end
  end

  assign m_tdata = out_use_mem ? rdata : '1;

endmodule

`default_nettype wire

### design/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  // a miss always reports all ones
  a_miss_all_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'hFFFF_FFFF)
    else $error("miss word without all-ones read_value");

  // a new result follows a word accepted into the input register, then the result register
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without accepted input word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // a result leaves only when taken
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result word dropped");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
